/* design/txs_pkg.sv */
package txs_pkg;

  // command codes
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_COLOUR = 2'd1;
  localparam logic [1:0] CMD_INTENS = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  // texel format codes (code 3 converts as linear grey)
  localparam logic [1:0] FMT_GAMMA  = 2'd0;
  localparam logic [1:0] FMT_NORMAL = 2'd1;
  localparam logic [1:0] FMT_LINEAR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_CHANS  = 2'd3;

  localparam int SIDE_W  = 11;   // size register width
  localparam int CFG_W   = 11;   // widest register
  localparam int LIMIT_W = 24;   // holds any width*height*channels
  localparam int ADDR_W  = 27;   // element address before range check

  // effective geometry handed from the register block to the sampler
  typedef struct packed {
    logic [1:0]          fmt;
    logic [SIDE_W-1:0]   width;
    logic [SIDE_W-1:0]   height;
    logic [2:0]          chans;
    logic [12:0]         wc;
    logic [LIMIT_W-1:0]  limit;
  } geom_t;

  typedef logic [15:0] conv_tab_t [256];

  // gamma 2.2: largest q with (q - 1/2) <= 16384 * (x/255)^(11/5), exact integers
  function automatic conv_tab_t build_gamma();
    conv_tab_t    tab;
    logic [191:0] p255;
    logic [191:0] rhs;
    logic [191:0] lhs;
    int           lo;
    int           hi;
    int           mid;
    p255 = 192'd1;
    for (int i = 0; i < 11; i++) p255 = p255 * 192'd255;
    for (int x = 0; x < 256; x++) begin
      if (x == 0) begin
        tab[x] = 16'd0;
      end else begin
        rhs = 192'd1;
        for (int i = 0; i < 11; i++) rhs = rhs * 192'(x);
        rhs = rhs << 75;
        lo = 0;
        hi = 16384;
        for (int it = 0; it < 16; it++) begin
          if (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            lhs = p255;
            for (int i = 0; i < 5; i++) lhs = lhs * 192'(2 * mid - 1);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
          end
        end
        tab[x] = 16'(lo);
      end
    end
    return tab;
  endfunction

  // signed normal 2x/255 - 1, rounded to nearest
  function automatic conv_tab_t build_normal();
    conv_tab_t tab;
    int        d;
    int        q;
    for (int x = 0; x < 256; x++) begin
      d = (x < 128) ? (255 - 2 * x) : (2 * x - 255);
      q = (d * 32768 + 255) / 510;
      tab[x] = (x < 128) ? 16'(-q) : 16'(q);
    end
    return tab;
  endfunction

  // linear x/255, rounded to nearest
  function automatic conv_tab_t build_linear();
    conv_tab_t tab;
    for (int x = 0; x < 256; x++) tab[x] = 16'((x * 32768 + 255) / 510);
    return tab;
  endfunction

  localparam conv_tab_t GAMMA_TAB  = build_gamma();
  localparam conv_tab_t NORMAL_TAB = build_normal();
  localparam conv_tab_t LINEAR_TAB = build_linear();

endpackage

/* design/txs_in_if.sv */
interface txs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] load_index;
  logic [7:0]  load_byte;
  logic [16:0] coord_u;
  logic [16:0] coord_v;

  modport source (output valid, cmd, load_index, load_byte, coord_u, coord_v, input ready);
  modport sink (input valid, cmd, load_index, load_byte, coord_u, coord_v, output ready);
endinterface

/* design/txs_out_if.sv */
interface txs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] chan_red;
  logic signed [15:0] chan_green;
  logic signed [15:0] chan_blue;
  logic               out_of_range;

  modport source (output valid, chan_red, chan_green, chan_blue, out_of_range, input ready);
  modport sink (input valid, chan_red, chan_green, chan_blue, out_of_range, output ready);
endinterface

/* design/txs_ram.sv */
module txs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem[addr] <= wdata;
      else rdata <= mem[addr];
    end
  end

endmodule

/* design/txs_cfg.sv */
module txs_cfg #(
  parameter int TEXEL_DEPTH = 65536,
  parameter int MAX_SIDE    = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_idx,
  input  logic [txs_pkg::CFG_W-1:0] cfg_data,
  output txs_pkg::geom_t            geo
);

  localparam logic [txs_pkg::LIMIT_W-1:0] LIMIT_CAP = txs_pkg::LIMIT_W'(TEXEL_DEPTH);

  logic [1:0]                 fmt_r;
  logic [txs_pkg::SIDE_W-1:0] wid_r;
  logic [txs_pkg::SIDE_W-1:0] hgt_r;
  logic [2:0]                 chn_r;
  logic [txs_pkg::SIDE_W-1:0] wid_eff;
  logic [txs_pkg::SIDE_W-1:0] hgt_eff;
  logic [2:0]                 chn_eff;
  logic [2*txs_pkg::SIDE_W-1:0] area_r;
  logic [12:0]                wc_r;
  logic [txs_pkg::LIMIT_W-1:0] limit_r;
  logic [txs_pkg::LIMIT_W-1:0] prod;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= txs_pkg::FMT_GAMMA;
      wid_r <= txs_pkg::SIDE_W'(1);
      hgt_r <= txs_pkg::SIDE_W'(1);
      chn_r <= 3'd3;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        txs_pkg::REG_FORMAT: fmt_r <= cfg_data[1:0];
        txs_pkg::REG_WIDTH:  wid_r <= cfg_data[txs_pkg::SIDE_W-1:0];
        txs_pkg::REG_HEIGHT: hgt_r <= cfg_data[txs_pkg::SIDE_W-1:0];
        txs_pkg::REG_CHANS:  chn_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // clamp sizes into their working range
  always_comb begin
    if (wid_r == '0) wid_eff = txs_pkg::SIDE_W'(1);
    else if (int'(wid_r) > MAX_SIDE) wid_eff = txs_pkg::SIDE_W'(MAX_SIDE);
    else wid_eff = wid_r;
    if (hgt_r == '0) hgt_eff = txs_pkg::SIDE_W'(1);
    else if (int'(hgt_r) > MAX_SIDE) hgt_eff = txs_pkg::SIDE_W'(MAX_SIDE);
    else hgt_eff = hgt_r;
    if (chn_r == 3'd0) chn_eff = 3'd1;
    else if (chn_r > 3'd4) chn_eff = 3'd4;
    else chn_eff = chn_r;
  end

  assign prod = txs_pkg::LIMIT_W'(area_r) * txs_pkg::LIMIT_W'(chn_eff);

  // derived sizes, registered from the clamped sizes; limit follows area_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_r  <= (2*txs_pkg::SIDE_W)'(1);
      wc_r    <= 13'd3;
      limit_r <= (LIMIT_CAP < txs_pkg::LIMIT_W'(3)) ? LIMIT_CAP : txs_pkg::LIMIT_W'(3);
    end else begin
      area_r  <= (2*txs_pkg::SIDE_W)'(wid_eff) * (2*txs_pkg::SIDE_W)'(hgt_eff);
      wc_r    <= 13'(wid_eff) * 13'(chn_eff);
      limit_r <= (prod > LIMIT_CAP) ? LIMIT_CAP : prod;
    end
  end

  assign geo.fmt    = fmt_r;
  assign geo.width  = wid_eff;
  assign geo.height = hgt_eff;
  assign geo.chans  = chn_eff;
  assign geo.wc     = wc_r;
  assign geo.limit  = limit_r;

endmodule

/* design/texture_load_and_nearest_sample.sv */
// Nearest-neighbour texture store. A load (cmd 0) converts one byte by the
// selected format into Q1.14 and writes it to the texel memory if it lies
// inside width*height*channels; it gives no result. A colour sample (cmd 1)
// returns three consecutive elements from (v*width+u)*channels, an intensity
// sample (cmd 2) one element from v*width+u; elements beyond the stored size
// read as 0 and set out_of_range. The single-ported texel memory is read one
// element per cycle. The block takes no new command until the last is done;
// a sample is done once its result enters the result register, which may
// wait on out_ch.ready. Command 3 is accepted and dropped. The texel memory
// is not cleared: only elements already loaded may be sampled. Derived sizes
// are registered and lag a configuration write.
module texture_load_and_nearest_sample #(
  parameter int TEXEL_DEPTH = 65536,
  parameter int MAX_SIDE    = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  txs_in_if.sink                    in_ch,
  txs_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_idx,
  input  logic [txs_pkg::CFG_W-1:0] cfg_data
);

  localparam int AW = $clog2(TEXEL_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_ADDR  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  txs_pkg::geom_t geo;

  logic [2:0]  state_r;
  logic [2:0]  state_nxt;
  logic [1:0]  cmd_r;
  logic [15:0] idx_r;
  logic [15:0] val_r;
  logic [15:0] val_nxt;
  logic [16:0] u_r;
  logic [16:0] v_r;
  logic [11:0] ui_r;
  logic [11:0] vi_r;
  logic [27:0] prod_u;
  logic [27:0] prod_v;
  logic [23:0] pix;
  logic [25:0] base;
  logic [txs_pkg::ADDR_W-1:0] addr_r;
  logic [txs_pkg::ADDR_W-1:0] rd_addr;
  logic        rd_oob;
  logic        rd_last;
  logic [1:0]  cnt_r;
  logic        ld_ok;
  logic        accept;
  logic        out_free;

  logic        rv_vld_r;
  logic [1:0]  rv_slot_r;
  logic        rv_oob_r;
  logic [15:0] rv_data;

  logic [15:0] acc_red_r;
  logic [15:0] acc_grn_r;
  logic [15:0] acc_blu_r;
  logic        acc_oor_r;

  logic        out_vld_r;
  logic [15:0] out_red_r;
  logic [15:0] out_grn_r;
  logic [15:0] out_blu_r;
  logic        out_oor_r;

  logic          ram_en;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [15:0]   ram_rdata;

  txs_cfg #(
    .TEXEL_DEPTH (TEXEL_DEPTH),
    .MAX_SIDE    (MAX_SIDE)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .geo      (geo)
  );

  txs_ram #(
    .WIDTH (16),
    .DEPTH (TEXEL_DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (val_r),
    .rdata (ram_rdata)
  );

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_vld_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // byte conversion by format table
  always_comb begin
    unique case (geo.fmt)
      txs_pkg::FMT_GAMMA:  val_nxt = txs_pkg::GAMMA_TAB[in_ch.load_byte];
      txs_pkg::FMT_NORMAL: val_nxt = txs_pkg::NORMAL_TAB[in_ch.load_byte];
      default:             val_nxt = txs_pkg::LINEAR_TAB[in_ch.load_byte];
    endcase
  end

  // pixel coordinates and element address
  assign prod_u = 28'(u_r) * 28'(geo.width - txs_pkg::SIDE_W'(1));
  assign prod_v = 28'(v_r) * 28'(geo.height - txs_pkg::SIDE_W'(1));
  assign pix    = 24'(vi_r) * 24'(geo.width) + 24'(ui_r);
  assign base   = 26'(vi_r) * 26'(geo.wc) + 26'(ui_r) * 26'(geo.chans);

  // memory access: load write or one element read per cycle
  assign ld_ok   = 24'(idx_r) < geo.limit;
  assign rd_addr = addr_r + txs_pkg::ADDR_W'(cnt_r);
  assign rd_oob  = rd_addr >= txs_pkg::ADDR_W'(geo.limit);
  assign rd_last = (cmd_r == txs_pkg::CMD_INTENS) || (cnt_r == 2'd2);

  always_comb begin
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = AW'(rd_addr);
    if (state_r == S_ADDR && cmd_r == txs_pkg::CMD_LOAD) begin
      ram_en   = ld_ok;
      ram_we   = ld_ok;
      ram_addr = AW'(idx_r);
    end else if (state_r == S_READ) begin
      ram_en = !rd_oob;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept && in_ch.cmd != txs_pkg::CMD_NONE) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ADDR;
      S_ADDR:  state_nxt = (cmd_r == txs_pkg::CMD_LOAD) ? S_IDLE : S_READ;
      S_READ:  if (rd_last) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= 2'd0;
      rv_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rv_vld_r <= (state_r == S_READ);
      if (state_r == S_ADDR) cnt_r <= 2'd0;
      else if (state_r == S_READ && !rd_last) cnt_r <= cnt_r + 2'd1;
    end
  end

  // item capture and address pipeline
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_ch.cmd;
      idx_r <= in_ch.load_index;
      val_r <= val_nxt;
      u_r   <= in_ch.coord_u;
      v_r   <= in_ch.coord_v;
    end
    if (state_r == S_MUL) begin
      ui_r <= prod_u[27:16];
      vi_r <= prod_v[27:16];
    end
    if (state_r == S_ADDR) begin
      addr_r <= (cmd_r == txs_pkg::CMD_COLOUR) ? txs_pkg::ADDR_W'(base)
                                               : txs_pkg::ADDR_W'(pix);
    end
    rv_slot_r <= cnt_r;
    rv_oob_r  <= rd_oob;
  end

  // gather returning elements, out of range reads as zero
  assign rv_data = rv_oob_r ? 16'd0 : ram_rdata;

  always_ff @(posedge clk) begin
    if (accept) begin
      acc_red_r <= 16'd0;
      acc_grn_r <= 16'd0;
      acc_blu_r <= 16'd0;
      acc_oor_r <= 1'b0;
    end else if (rv_vld_r) begin
      case (rv_slot_r)
        2'd0:    acc_red_r <= rv_data;
        2'd1:    acc_grn_r <= rv_data;
        default: acc_blu_r <= rv_data;
      endcase
      acc_oor_r <= acc_oor_r | rv_oob_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_red_r <= acc_red_r;
      out_grn_r <= acc_grn_r;
      out_blu_r <= acc_blu_r;
      out_oor_r <= acc_oor_r;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.chan_red     = out_red_r;
  assign out_ch.chan_green   = out_grn_r;
  assign out_ch.chan_blue    = out_blu_r;
  assign out_ch.out_of_range = out_oor_r;

  // read data only follows a read issue
  a_rv_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    rv_vld_r |-> $past(state_r == S_READ))
    else $error("read return without issue");

  // all reads drained before the result is handed over
  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |-> !rv_vld_r)
    else $error("result formed with read outstanding");

  // a new result only comes out of the final state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside final state");

  // intensity results carry zero second and third elements
  a_intens_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && cmd_r == txs_pkg::CMD_INTENS) |->
      (acc_grn_r == 16'd0 && acc_blu_r == 16'd0))
    else $error("intensity sample with stray elements");

  // read counter stays within three elements
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> cnt_r != 2'd3)
    else $error("read counter overran");

endmodule
